FILE: design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons follows ante, outside reset.
`define ASSERT_LAT2(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> ##1 (cons)) \
        else $error("assertion failed: two-cycle latency");

`endif

FILE: design/rvid_pkg.sv
// Types, codes and lookup functions for the RV32I instruction decoder.
`default_nettype none

package rvid_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;
    localparam logic [2:0] F3_ADD_SUB = 3'b000;
    localparam logic [2:0] F3_SHR     = 3'b101;

    localparam logic [31:0] WORD_ECALL = 32'h0000_0073;

    // Dense instruction codes
    localparam logic [5:0] IC_NONE  = 6'd0;
    localparam logic [5:0] IC_LUI   = 6'd1;
    localparam logic [5:0] IC_AUIPC = 6'd2;
    localparam logic [5:0] IC_JAL   = 6'd3;
    localparam logic [5:0] IC_JALR  = 6'd4;
    localparam logic [5:0] IC_BEQ   = 6'd5;
    localparam logic [5:0] IC_BNE   = 6'd6;
    localparam logic [5:0] IC_BLT   = 6'd7;
    localparam logic [5:0] IC_BGE   = 6'd8;
    localparam logic [5:0] IC_BLTU  = 6'd9;
    localparam logic [5:0] IC_BGEU  = 6'd10;
    localparam logic [5:0] IC_LB    = 6'd11;
    localparam logic [5:0] IC_LH    = 6'd12;
    localparam logic [5:0] IC_LW    = 6'd13;
    localparam logic [5:0] IC_LBU   = 6'd14;
    localparam logic [5:0] IC_LHU   = 6'd15;
    localparam logic [5:0] IC_SB    = 6'd16;
    localparam logic [5:0] IC_SH    = 6'd17;
    localparam logic [5:0] IC_SW    = 6'd18;
    localparam logic [5:0] IC_ADDI  = 6'd19;
    localparam logic [5:0] IC_SLTI  = 6'd20;
    localparam logic [5:0] IC_SLTIU = 6'd21;
    localparam logic [5:0] IC_XORI  = 6'd22;
    localparam logic [5:0] IC_ORI   = 6'd23;
    localparam logic [5:0] IC_ANDI  = 6'd24;
    localparam logic [5:0] IC_SLLI  = 6'd25;
    localparam logic [5:0] IC_SRLI  = 6'd26;
    localparam logic [5:0] IC_SRAI  = 6'd27;
    localparam logic [5:0] IC_ADD   = 6'd28;
    localparam logic [5:0] IC_SUB   = 6'd29;
    localparam logic [5:0] IC_SLL   = 6'd30;
    localparam logic [5:0] IC_SLT   = 6'd31;
    localparam logic [5:0] IC_SLTU  = 6'd32;
    localparam logic [5:0] IC_XOR   = 6'd33;
    localparam logic [5:0] IC_SRL   = 6'd34;
    localparam logic [5:0] IC_SRA   = 6'd35;
    localparam logic [5:0] IC_OR    = 6'd36;
    localparam logic [5:0] IC_AND   = 6'd37;
    localparam logic [5:0] IC_ECALL = 6'd38;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_U    = 3'd5,
        FMT_J    = 3'd6,
        FMT_SYS  = 3'd7
    } fmt_t;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } acc_t;

    typedef struct packed {
        logic [5:0]  code;
        fmt_t        fmt;
        acc_t        acc;
        logic [2:0]  nbytes;
        logic        branch;
        logic [31:0] imm;
    } dec_t;

    function automatic logic [5:0] branch_code(input logic [2:0] f3);
        logic [5:0] c;
        case (f3)
            3'd0:    c = IC_BEQ;
            3'd1:    c = IC_BNE;
            3'd4:    c = IC_BLT;
            3'd5:    c = IC_BGE;
            3'd6:    c = IC_BLTU;
            3'd7:    c = IC_BGEU;
            default: c = IC_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] load_code(input logic [2:0] f3);
        logic [5:0] c;
        case (f3)
            3'd0:    c = IC_LB;
            3'd1:    c = IC_LH;
            3'd2:    c = IC_LW;
            3'd4:    c = IC_LBU;
            3'd5:    c = IC_LHU;
            default: c = IC_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] load_nbytes(input logic [2:0] f3);
        logic [2:0] n;
        case (f3)
            3'd0, 3'd4: n = 3'd1;
            3'd1, 3'd5: n = 3'd2;
            3'd2:       n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] store_code(input logic [2:0] f3);
        logic [5:0] c;
        case (f3)
            3'd0:    c = IC_SB;
            3'd1:    c = IC_SH;
            3'd2:    c = IC_SW;
            default: c = IC_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] store_nbytes(input logic [2:0] f3);
        logic [2:0] n;
        case (f3)
            3'd0:    n = 3'd1;
            3'd1:    n = 3'd2;
            3'd2:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] opimm_code(input logic [2:0] f3);
        logic [5:0] c;
        case (f3)
            3'd0:    c = IC_ADDI;
            3'd1:    c = IC_SLLI;
            3'd2:    c = IC_SLTI;
            3'd3:    c = IC_SLTIU;
            3'd4:    c = IC_XORI;
            3'd6:    c = IC_ORI;
            3'd7:    c = IC_ANDI;
            default: c = IC_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] op_code(input logic [2:0] f3);
        logic [5:0] c;
        case (f3)
            3'd0:    c = IC_ADD;
            3'd1:    c = IC_SLL;
            3'd2:    c = IC_SLT;
            3'd3:    c = IC_SLTU;
            3'd4:    c = IC_XOR;
            3'd5:    c = IC_SRL;
            3'd6:    c = IC_OR;
            3'd7:    c = IC_AND;
            default: c = IC_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/rvid_decode.sv
// Combinational decode of one RV32I word into code, format, access and immediate.
`default_nettype none

module rvid_decode
    import rvid_pkg::*;
(
    input  wire logic [31:0] word,
    output dec_t             dec
);

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    always_comb
    begin
        dec.code   = IC_NONE;
        dec.fmt    = FMT_NONE;
        dec.acc    = ACC_NONE;
        dec.nbytes = 3'd0;
        dec.branch = 1'b0;
        case (opc)
            OPC_LUI:
            begin
                dec.code = IC_LUI;
                dec.fmt  = FMT_U;
            end
            OPC_AUIPC:
            begin
                dec.code = IC_AUIPC;
                dec.fmt  = FMT_U;
            end
            OPC_JAL:
            begin
                dec.code   = IC_JAL;
                dec.fmt    = FMT_J;
                dec.branch = 1'b1;
            end
            OPC_JALR:
            begin
                dec.code   = IC_JALR;
                dec.fmt    = FMT_I;
                dec.branch = 1'b1;
            end
            OPC_BRANCH:
            begin
                dec.code   = branch_code(f3);
                dec.fmt    = FMT_B;
                dec.branch = 1'b1;
            end
            OPC_LOAD:
            begin
                dec.code   = load_code(f3);
                dec.fmt    = FMT_I;
                dec.nbytes = load_nbytes(f3);
                dec.acc    = (load_nbytes(f3) != 3'd0) ? ACC_READ : ACC_NONE;
            end
            OPC_STORE:
            begin
                dec.code   = store_code(f3);
                dec.fmt    = FMT_S;
                dec.nbytes = store_nbytes(f3);
                dec.acc    = (store_nbytes(f3) != 3'd0) ? ACC_WRITE : ACC_NONE;
            end
            OPC_OPIMM:
            begin
                if (f3 == F3_SHR)
                begin
                    // bad funct7 on a right shift leaves the word undecoded
                    if (f7 == F7_BASE)
                    begin
                        dec.code = IC_SRLI;
                        dec.fmt  = FMT_I;
                    end
                    else if (f7 == F7_ALT)
                    begin
                        dec.code = IC_SRAI;
                        dec.fmt  = FMT_I;
                    end
                end
                else
                begin
                    dec.code = opimm_code(f3);
                    dec.fmt  = FMT_I;
                end
            end
            OPC_OP:
            begin
                dec.fmt = FMT_R;
                if (f7 == F7_BASE)
                    dec.code = op_code(f3);
                else if (f7 == F7_ALT && f3 == F3_ADD_SUB)
                    dec.code = IC_SUB;
                else if (f7 == F7_ALT && f3 == F3_SHR)
                    dec.code = IC_SRA;
            end
            OPC_SYSTEM:
            begin
                dec.fmt = FMT_SYS;
                if (word == WORD_ECALL)
                    dec.code = IC_ECALL;
            end
            default:
            begin
                dec.code = IC_NONE;
            end
        endcase

        // Assemble the immediate for the decoded format
        case (dec.fmt)
            FMT_I, FMT_SYS: dec.imm = {{20{word[31]}}, word[31:20]};
            FMT_S:          dec.imm = {{20{word[31]}}, word[31:25], word[11:7]};
            FMT_B:          dec.imm = {{19{word[31]}}, word[31], word[7], word[30:25],
                                       word[11:8], 1'b0};
            FMT_U:          dec.imm = {word[31:12], 12'd0};
            FMT_J:          dec.imm = {{11{word[31]}}, word[31], word[19:12], word[20],
                                       word[30:21], 1'b0};
            default:        dec.imm = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/rv32i_instruction_decoder.sv
// Top level of the RV32I instruction decoder: input register, decode, result register.
`default_nettype none

// RV32I instruction decoder. Raise start with a word on instruction_word; the
// word is taken at that clock edge (busy is always low, so a word can be taken
// at every edge). The word passes the input register, then the decode logic
// into the result register, and the decoded result then sits on the result ports
// for one cycle with done high; the receiver cannot stall it and must take it
// in that cycle. Throughput is one word per cycle. Results come out in the
// order the words went in. The decode gives a dense instruction code (0 for
// anything not recognized), the format type, the memory access kind and size,
// a branch flag, the raw opcode, funct3 and register fields, and the
// sign-extended immediate.
module rv32i_instruction_decoder
    import rvid_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] instruction_word,
    output logic             done,
    output logic [5:0]       instr_code,
    output logic [2:0]       format_type,
    output logic [1:0]       mem_access,
    output logic [2:0]       access_bytes,
    output logic             branch_flag,
    output logic [6:0]       opcode_bits,
    output logic [2:0]       funct3_bits,
    output logic [4:0]       src1_index,
    output logic [4:0]       src2_index,
    output logic [4:0]       dest_index,
    output logic signed [31:0] immediate
);

    logic        in_valid_reg;
    logic [31:0] word_reg;
    logic        done_reg;
    logic [31:0] res_word_reg;
    dec_t        res_reg;
    dec_t        dec_next;

    // Every stage advances each cycle, so no word is ever refused
    assign busy = 1'b0;

    rvid_decode u_decode (
        .word (word_reg),
        .dec  (dec_next)
    );

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    // Payload: capture the word, then register its decoded form
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            word_reg <= instruction_word;
        if (in_valid_reg)
        begin
            res_word_reg <= word_reg;
            res_reg      <= dec_next;
        end
    end

    assign done         = done_reg;
    assign instr_code   = res_reg.code;
    assign format_type  = res_reg.fmt;
    assign mem_access   = res_reg.acc;
    assign access_bytes = res_reg.nbytes;
    assign branch_flag  = res_reg.branch;
    assign opcode_bits  = res_word_reg[6:0];
    assign funct3_bits  = res_word_reg[14:12];
    assign src1_index   = res_word_reg[19:15];
    assign src2_index   = res_word_reg[24:20];
    assign dest_index   = res_word_reg[11:7];
    assign immediate    = res_reg.imm;

`include "assert_macros.svh"

    `ASSERT_LAT2(a_latency, clk, rst_n, start && !busy, done)
    `ASSERT_IMP(a_access_size, clk, rst_n, done, (mem_access == ACC_NONE) == (access_bytes == 3'd0))
    `ASSERT_IMP(a_branch_fmt, clk, rst_n, done && branch_flag, format_type == FMT_B || format_type == FMT_J || format_type == FMT_I)
    `ASSERT_IMP(a_r_no_imm, clk, rst_n, done && format_type == FMT_R, immediate == 32'sd0)

endmodule

`default_nettype wire

FILE: tb/tb_rv32i_instruction_decoder.sv
// Self-checking testbench for the RV32I instruction decoder: corner words, every operation, random streams.
`default_nettype none

module tb_rv32i_instruction_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rvid_pkg::*;

    // Cycles with no word taken and no result seen before the run is declared hung.
    // The slowest correct stretch is a sender gap or a drain of the pipeline,
    // so this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT = 200;
    localparam int unsigned REPORT_LIMIT = 10;

    // funct3 encodings that the package does not name
    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [2:0] F3_BLT    = 3'd4;
    localparam logic [2:0] F3_BGE    = 3'd5;
    localparam logic [2:0] F3_BLTU   = 3'd6;
    localparam logic [2:0] F3_BGEU   = 3'd7;
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;
    localparam logic [2:0] F3_SLL    = 3'd1;
    localparam logic [2:0] F3_SLT    = 3'd2;
    localparam logic [2:0] F3_SLTU   = 3'd3;
    localparam logic [2:0] F3_XOR    = 3'd4;
    localparam logic [2:0] F3_OR     = 3'd6;
    localparam logic [2:0] F3_AND    = 3'd7;

    // One decoded word, every field that the block reports
    typedef struct packed {
        logic [5:0]  code;
        fmt_t        fmt;
        acc_t        acc;
        logic [2:0]  nbytes;
        logic        branch;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  rd;
        logic [31:0] imm;
    } decoded_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instruction_word;
    logic        done;
    logic [5:0]  instr_code;
    logic [2:0]  format_type;
    logic [1:0]  mem_access;
    logic [2:0]  access_bytes;
    logic        branch_flag;
    logic [6:0]  opcode_bits;
    logic [2:0]  funct3_bits;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [4:0]  dest_index;
    logic signed [31:0] immediate;

    // Decodes waiting for their result, oldest first, with the words they came from
    decoded_word_t pending_decodes[$];
    logic [31:0]   pending_words[$];

    int unsigned words_issued;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned sender_idle_pct;
    logic [38:0] codes_seen;
    logic [7:0]  formats_seen;

    rv32i_instruction_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .instruction_word (instruction_word),
        .done             (done),
        .instr_code       (instr_code),
        .format_type      (format_type),
        .mem_access       (mem_access),
        .access_bytes     (access_bytes),
        .branch_flag      (branch_flag),
        .opcode_bits      (opcode_bits),
        .funct3_bits      (funct3_bits),
        .src1_index       (src1_index),
        .src2_index       (src2_index),
        .dest_index       (dest_index),
        .immediate        (immediate)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Independent decode of one word: register slices always, then the class
    // of the major opcode, then the immediate that belongs to that class.
    function automatic decoded_word_t decode_word(input logic [31:0] w);
        decoded_word_t d;
        logic [2:0] f3;
        logic [6:0] f7;
        d = '0;
        f3 = w[14:12];
        f7 = w[31:25];
        d.opc = w[6:0];
        d.f3 = f3;
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.rd = w[11:7];
        case (w[6:0])
            OPC_LUI:
            begin
                d.code = IC_LUI;
                d.fmt = FMT_U;
            end
            OPC_AUIPC:
            begin
                d.code = IC_AUIPC;
                d.fmt = FMT_U;
            end
            OPC_JAL:
            begin
                d.code = IC_JAL;
                d.fmt = FMT_J;
                d.branch = 1'b1;
            end
            OPC_JALR:
            begin
                // funct3 is ignored for JALR
                d.code = IC_JALR;
                d.fmt = FMT_I;
                d.branch = 1'b1;
            end
            OPC_BRANCH:
            begin
                d.fmt = FMT_B;
                d.branch = 1'b1;
                case (f3)
                    F3_BEQ:  d.code = IC_BEQ;
                    F3_BNE:  d.code = IC_BNE;
                    F3_BLT:  d.code = IC_BLT;
                    F3_BGE:  d.code = IC_BGE;
                    F3_BLTU: d.code = IC_BLTU;
                    F3_BGEU: d.code = IC_BGEU;
                    default: d.code = IC_NONE;
                endcase
            end
            OPC_LOAD:
            begin
                d.fmt = FMT_I;
                case (f3)
                    F3_BYTE:   begin d.code = IC_LB;  d.nbytes = 3'd1; end
                    F3_HALF:   begin d.code = IC_LH;  d.nbytes = 3'd2; end
                    F3_WORD:   begin d.code = IC_LW;  d.nbytes = 3'd4; end
                    F3_BYTE_U: begin d.code = IC_LBU; d.nbytes = 3'd1; end
                    F3_HALF_U: begin d.code = IC_LHU; d.nbytes = 3'd2; end
                    default:   d.code = IC_NONE;
                endcase
                if (d.nbytes != 3'd0)
                    d.acc = ACC_READ;
            end
            OPC_STORE:
            begin
                d.fmt = FMT_S;
                case (f3)
                    F3_BYTE: begin d.code = IC_SB; d.nbytes = 3'd1; end
                    F3_HALF: begin d.code = IC_SH; d.nbytes = 3'd2; end
                    F3_WORD: begin d.code = IC_SW; d.nbytes = 3'd4; end
                    default: d.code = IC_NONE;
                endcase
                if (d.nbytes != 3'd0)
                    d.acc = ACC_WRITE;
            end
            OPC_OPIMM:
            begin
                if (f3 == F3_SHR)
                begin
                    // a shift-right with a bad funct7 stays undecoded, format none
                    if (f7 == F7_BASE)
                    begin
                        d.code = IC_SRLI;
                        d.fmt = FMT_I;
                    end
                    else if (f7 == F7_ALT)
                    begin
                        d.code = IC_SRAI;
                        d.fmt = FMT_I;
                    end
                end
                else
                begin
                    d.fmt = FMT_I;
                    case (f3)
                        F3_ADD_SUB: d.code = IC_ADDI;
                        F3_SLL:     d.code = IC_SLLI;
                        F3_SLT:     d.code = IC_SLTI;
                        F3_SLTU:    d.code = IC_SLTIU;
                        F3_XOR:     d.code = IC_XORI;
                        F3_OR:      d.code = IC_ORI;
                        default:    d.code = IC_ANDI;
                    endcase
                end
            end
            OPC_OP:
            begin
                // R-type keeps its format even when the funct pair is unknown
                d.fmt = FMT_R;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD_SUB: d.code = IC_ADD;
                        F3_SLL:     d.code = IC_SLL;
                        F3_SLT:     d.code = IC_SLT;
                        F3_SLTU:    d.code = IC_SLTU;
                        F3_XOR:     d.code = IC_XOR;
                        F3_SHR:     d.code = IC_SRL;
                        F3_OR:      d.code = IC_OR;
                        default:    d.code = IC_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD_SUB)
                    d.code = IC_SUB;
                else if (f7 == F7_ALT && f3 == F3_SHR)
                    d.code = IC_SRA;
            end
            OPC_SYSTEM:
            begin
                d.fmt = FMT_SYS;
                if (w == WORD_ECALL)
                    d.code = IC_ECALL;
            end
            default:
            begin
            end
        endcase
        case (d.fmt)
            FMT_I, FMT_SYS: d.imm = {{20{w[31]}}, w[31:20]};
            FMT_S:          d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            FMT_B:          d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_U:          d.imm = {w[31:12], 12'd0};
            FMT_J:          d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:        d.imm = 32'd0;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [6:0] known_opcode(input int unsigned idx);
        logic [6:0] opc;
        case (idx)
            0:       opc = OPC_LUI;
            1:       opc = OPC_AUIPC;
            2:       opc = OPC_JAL;
            3:       opc = OPC_JALR;
            4:       opc = OPC_BRANCH;
            5:       opc = OPC_LOAD;
            6:       opc = OPC_STORE;
            7:       opc = OPC_OPIMM;
            8:       opc = OPC_OP;
            default: opc = OPC_SYSTEM;
        endcase
        return opc;
    endfunction

    // Mostly well-formed words with random content; some pure noise and
    // some words on or next to the single ECALL encoding.
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [6:0] opc;
        int unsigned pick;
        w = $urandom;
        pick = $urandom_range(99);
        if (pick < 15)
            return w;
        if (pick < 18)
            return WORD_ECALL;
        opc = known_opcode($urandom_range(9));
        w[6:0] = opc;
        // bias funct7 toward the encodings that decode
        if (opc == OPC_OP || (opc == OPC_OPIMM && w[14:12] == F3_SHR))
        begin
            case ($urandom_range(3))
                0, 1:    w[31:25] = F7_BASE;
                2:       w[31:25] = F7_ALT;
                default: w[31:25] = w[31:25];
            endcase
        end
        // system words one bit away from ECALL
        if (opc == OPC_SYSTEM && $urandom_range(2) == 0)
        begin
            w[31:7] = '0;
            w[$urandom_range(31, 7)] = 1'b1;
        end
        return w;
    endfunction

    task automatic report_field(input string name, input logic [31:0] word,
                                input logic [31:0] want, input logic [31:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("  %s wrong for word %h: expected %h, got %h", name, word, want, seen);
        end
    endtask

    // Sample at the rising edge: take the word that the handshake moves,
    // predict its decode, and check any result that is marked valid.
    always @(posedge clk)
    begin : result_checker
        decoded_word_t want;
        logic [31:0] word;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_decodes.push_back(decode_word(instruction_word));
                pending_words.push_back(instruction_word);
                words_issued++;
            end
            if (done)
            begin
                if (pending_decodes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("  result with code %0d came with no word outstanding",
                                 instr_code);
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    word = pending_words.pop_front();
                    report_field("instr_code", word, 32'(want.code), 32'(instr_code));
                    report_field("format_type", word, 32'(want.fmt), 32'(format_type));
                    report_field("mem_access", word, 32'(want.acc), 32'(mem_access));
                    report_field("access_bytes", word, 32'(want.nbytes), 32'(access_bytes));
                    report_field("branch_flag", word, 32'(want.branch), 32'(branch_flag));
                    report_field("opcode_bits", word, 32'(want.opc), 32'(opcode_bits));
                    report_field("funct3_bits", word, 32'(want.f3), 32'(funct3_bits));
                    report_field("src1_index", word, 32'(want.rs1), 32'(src1_index));
                    report_field("src2_index", word, 32'(want.rs2), 32'(src2_index));
                    report_field("dest_index", word, 32'(want.rd), 32'(dest_index));
                    report_field("immediate", word, want.imm, immediate);
                    codes_seen[want.code] = 1'b1;
                    formats_seen[want.fmt] = 1'b1;
                    results_checked++;
                end
            end
            // reset the hang counter on any handshake or result
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Drop the run if the block stops moving words for too long.
    initial
    begin : hang_watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("No progress for %0d cycles with %0d words outstanding",
                 QUIET_LIMIT, pending_decodes.size());
        $display("Regression FAIL");
        $finish;
    end

    // Present one word: maybe idle first (start low, junk on the bus), then
    // hold start high with the word until the block takes it. Leave start
    // high afterwards so back-to-back words stream at full rate.
    task automatic issue_word(input logic [31:0] w);
        int unsigned gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                instruction_word <= $urandom;
            end
        end
        @(negedge clk);
        start <= 1'b1;
        instruction_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold off the sender until every word taken so far has produced its result.
    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (pending_decodes.size() != 0)
            @(negedge clk);
    endtask

    // Field extremes and each decode corner: unknown opcode, unknown funct3
    // per class, unknown R-type funct pair, bad shift-right funct7, unchecked
    // SLLI funct7 and JALR funct3, ECALL and its near neighbors.
    task automatic test_corner_words();
        issue_word(32'h0000_0000);
        issue_word(32'hFFFF_FFFF);
        issue_word(WORD_ECALL);
        issue_word(32'h0010_0073);
        issue_word(pack_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, OPC_SYSTEM));
        issue_word(pack_word(7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OPC_BRANCH));
        issue_word(pack_word(7'h00, 5'd0, 5'd0, 3'd3, 5'd0, OPC_BRANCH));
        issue_word(pack_word(7'h7F, 5'd31, 5'd31, 3'd3, 5'd31, OPC_LOAD));
        issue_word(pack_word(7'h00, 5'd5, 5'd6, 3'd6, 5'd7, OPC_LOAD));
        issue_word(pack_word(7'h3F, 5'd1, 5'd2, 3'd7, 5'd3, OPC_LOAD));
        issue_word(pack_word(7'h7F, 5'd31, 5'd31, 3'd3, 5'd31, OPC_STORE));
        issue_word(pack_word(7'h40, 5'd0, 5'd0, 3'd7, 5'd0, OPC_STORE));
        issue_word(pack_word(F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_OP));
        issue_word(pack_word(7'h01, 5'd4, 5'd5, F3_ADD_SUB, 5'd6, OPC_OP));
        issue_word(pack_word(7'h10, 5'd3, 5'd8, F3_SHR, 5'd9, OPC_OPIMM));
        issue_word(pack_word(7'h7F, 5'd31, 5'd31, F3_SHR, 5'd31, OPC_OPIMM));
        issue_word(pack_word(7'h7F, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_OPIMM));
        issue_word(pack_word(7'h55, 5'd10, 5'd11, 3'd7, 5'd12, OPC_JALR));
        issue_word({20'hFFFFF, 5'd31, OPC_LUI});
        issue_word({20'h80000, 5'd0, OPC_AUIPC});
        issue_word({1'b1, 10'd0, 1'b0, 8'd0, 5'd1, OPC_JAL});
        issue_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL});
        issue_word(pack_word(7'h40, 5'd0, 5'd0, F3_WORD, 5'd0, OPC_STORE));
        issue_word(pack_word(7'h3F, 5'd31, 5'd31, F3_BYTE, 5'd31, OPC_STORE));
    endtask

    // Every major opcode with every funct3, then the alternate-funct7 forms.
    task automatic test_every_operation();
        for (int unsigned k = 0; k < 10; k++)
            for (int unsigned f = 0; f < 8; f++)
                issue_word(pack_word(F7_BASE, 5'($urandom_range(31)), 5'($urandom_range(31)),
                                     f[2:0], 5'($urandom_range(31)), known_opcode(k)));
        issue_word(pack_word(F7_ALT, 5'($urandom_range(31)), 5'($urandom_range(31)),
                             F3_ADD_SUB, 5'($urandom_range(31)), OPC_OP));
        issue_word(pack_word(F7_ALT, 5'($urandom_range(31)), 5'($urandom_range(31)),
                             F3_SHR, 5'($urandom_range(31)), OPC_OP));
        issue_word(pack_word(F7_ALT, 5'($urandom_range(31)), 5'($urandom_range(31)),
                             F3_SHR, 5'($urandom_range(31)), OPC_OPIMM));
        drain_pending();
    endtask

    // A random stream at a given sender idle rate, paused once halfway until
    // the block has emptied.
    task automatic test_random_stream(input int unsigned count, input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain_pending();
            issue_word(random_instruction());
        end
        drain_pending();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        instruction_word = 32'd0;
        words_issued = 0;
        results_checked = 0;
        mismatches = 0;
        quiet_cycles = 0;
        sender_idle_pct = 7;
        codes_seen = '0;
        formats_seen = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_words();
        test_every_operation();
        test_random_stream(215, 7);
        test_random_stream(215, 56);
        test_random_stream(215, 0);

        // let the pipe settle and catch any stray result
        drain_pending();
        repeat (8) @(posedge clk);

        if (pending_decodes.size() != 0)
        begin
            mismatches++;
            $display("%0d words never produced a result", pending_decodes.size());
        end
        $display("Covered %0d words, %0d results checked: %0d of 39 codes, %0d of 8 formats.",
                 words_issued, results_checked, $countones(codes_seen),
                 $countones(formats_seen));
        $display("Field mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
